// ===== rtl/core/cma_pkg.sv =====
// Shared types and constants of the centered moving average block.
package cma_pkg;

    localparam int unsigned HALF_SPAN = 5;
    localparam int unsigned WIN_LEN = 2 * HALF_SPAN + 1;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned SUM_W = SAMPLE_W + $clog2(WIN_LEN);
    localparam int unsigned SEEN_W = $clog2(WIN_LEN + 1);
    localparam int unsigned K_W = $clog2(HALF_SPAN + 1);
    localparam int unsigned DROP_IDX_W = (HALF_SPAN > 1) ? $clog2(HALF_SPAN) : 1;

    // Reciprocal of the window size, exact for every sum of SUM_W bits.
    localparam int unsigned RECIP_SHIFT = SUM_W + $clog2(WIN_LEN);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + WIN_LEN - 1) / WIN_LEN;
    localparam int unsigned RECIP_W = RECIP_SHIFT - $clog2(WIN_LEN) + 2;
    localparam int unsigned PROD_W = SUM_W + RECIP_W;

    localparam int unsigned JOBQ_DEPTH = 4;
    localparam int unsigned JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
    localparam int unsigned JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);
    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                block_end;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                final_result;
    } out_item_t;

    typedef struct packed {
        logic                               flush;
        logic [SUM_W-1:0]                   sum;
        logic [HALF_SPAN-1:0][SAMPLE_W-1:0] drops;
        logic [K_W-1:0]                     k_first;
    } cma_job_t;

endpackage

// ===== rtl/core/centered_moving_average_11.sv =====
// Top level of the centered moving average filter over blocks of 16-bit samples.
// A result passes the job queue, back-end sequencer, product register and result queue.
// Throughput: one sample per cycle unless full; a block end ties up the back end until flushed.
// The back end flushes one window position per cycle while the result queue has room.
// Reset: asynchronous active low; clears the window, running sum, count and both queues.
module centered_moving_average_11 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  cma_pkg::in_item_t   item,
    output logic                empty,
    input  logic                pop,
    output cma_pkg::out_item_t  result
);

    logic              accept;
    logic              job_push, job_full, job_pop, job_empty;
    cma_pkg::cma_job_t job_in, job_out;

    assign full   = job_full;
    assign accept = push && !job_full;

    cma_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .job_push (job_push),
        .job      (job_in)
    );

    cma_job_queue u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (job_in),
        .full    (job_full),
        .pop     (job_pop),
        .empty   (job_empty),
        .job_out (job_out)
    );

    cma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

// ===== rtl/core/cma_front.sv =====
// Front end: window shift line, running sum, and a job for each block end or result-owing sample.
module cma_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  cma_pkg::in_item_t   item,
    output logic                job_push,
    output cma_pkg::cma_job_t   job
);

    logic [cma_pkg::WIN_LEN-1:0][cma_pkg::SAMPLE_W-1:0] window_reg, window_next;
    logic [cma_pkg::WIN_LEN-1:0][cma_pkg::SAMPLE_W-1:0] window_shift;
    logic [cma_pkg::SUM_W-1:0]  sum_reg, sum_next, sum_shift;
    logic [cma_pkg::SEEN_W-1:0] seen_reg, seen_next, seen_shift;
    logic                       enough;

    always_comb
    begin
        window_shift[0] = item.sample;
        for (int i = 1; i < cma_pkg::WIN_LEN; i++)
        begin
            window_shift[i] = window_reg[i-1];
        end
        sum_shift = sum_reg
                  - cma_pkg::SUM_W'(window_reg[cma_pkg::WIN_LEN-1])
                  + cma_pkg::SUM_W'(item.sample);
        if (seen_reg < cma_pkg::SEEN_W'(cma_pkg::WIN_LEN))
        begin
            seen_shift = seen_reg + 1'b1;
        end
        else
        begin
            seen_shift = seen_reg;
        end
        enough = (seen_shift >= cma_pkg::SEEN_W'(cma_pkg::HALF_SPAN + 1));

        job.flush = item.block_end;
        job.sum   = sum_shift;
        for (int j = 0; j < cma_pkg::HALF_SPAN; j++)
        begin
            job.drops[j] = window_shift[cma_pkg::WIN_LEN-1-j];
        end
        if (enough)
        begin
            job.k_first = '0;
        end
        else
        begin
            job.k_first = cma_pkg::K_W'(cma_pkg::SEEN_W'(cma_pkg::HALF_SPAN + 1) - seen_shift);
        end
        job_push = accept && (item.block_end || enough);

        window_next = window_reg;
        sum_next    = sum_reg;
        seen_next   = seen_reg;
        if (accept)
        begin
            if (item.block_end)
            begin
                window_next = '0;
                sum_next    = '0;
                seen_next   = '0;
            end
            else
            begin
                window_next = window_shift;
                sum_next    = sum_shift;
                seen_next   = seen_shift;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            sum_reg    <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            window_reg <= window_next;
            sum_reg    <= sum_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

// ===== rtl/core/cma_job_queue.sv =====
// Short job queue between the front end and the back end.
module cma_job_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cma_pkg::cma_job_t  job_in,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output cma_pkg::cma_job_t  job_out
);

    cma_pkg::cma_job_t               store_reg [cma_pkg::JOBQ_DEPTH];
    logic [cma_pkg::JOBQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [cma_pkg::JOBQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [cma_pkg::JOBQ_CNT_W-1:0]  count_reg, count_next;
    logic                            do_push, do_pop;

    assign full    = (count_reg == cma_pkg::JOBQ_CNT_W'(cma_pkg::JOBQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/cma_back.sv =====
// Back end: flush sequencer, reciprocal divide stage and result queue.
module cma_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    input  cma_pkg::cma_job_t   job,
    output logic                job_pop,
    input  logic                pop,
    output logic                empty,
    output cma_pkg::out_item_t  result
);

    localparam logic [cma_pkg::RECIP_W-1:0] RECIP_C = cma_pkg::RECIP_W'(cma_pkg::RECIP);

    logic                                               active_reg, active_next;
    logic                                               flush_reg, flush_next;
    logic [cma_pkg::SUM_W-1:0]                          cur_sum_reg, cur_sum_next;
    logic [cma_pkg::HALF_SPAN-1:0][cma_pkg::SAMPLE_W-1:0] drops_reg, drops_next;
    logic [cma_pkg::K_W-1:0]                            k_reg, k_next;
    logic [cma_pkg::K_W-1:0]                            k_first_reg, k_first_next;

    logic                                               mul_valid_reg;
    logic                                               mul_last_reg;
    logic [cma_pkg::PROD_W-1:0]                         prod_reg;

    cma_pkg::out_item_t                                 outq_reg [cma_pkg::OUTQ_DEPTH];
    logic [cma_pkg::OUTQ_PTR_W-1:0]                     out_wr_reg, out_rd_reg;
    logic [cma_pkg::OUTQ_CNT_W-1:0]                     out_count_reg, out_count_next;

    logic can_issue, issue, emit, last_k, finishing, load, do_pop;
    cma_pkg::out_item_t out_wr_item;

    assign last_k    = (k_reg == cma_pkg::K_W'(cma_pkg::HALF_SPAN));
    assign can_issue = (out_count_reg + cma_pkg::OUTQ_CNT_W'(mul_valid_reg))
                       < cma_pkg::OUTQ_CNT_W'(cma_pkg::OUTQ_DEPTH);
    assign issue     = active_reg && can_issue;
    assign emit      = issue && (!flush_reg || (k_reg >= k_first_reg));
    assign finishing = issue && (!flush_reg || last_k);
    assign load      = !job_empty && (!active_reg || finishing);
    assign job_pop   = load;

    always_comb
    begin
        active_next  = active_reg;
        flush_next   = flush_reg;
        cur_sum_next = cur_sum_reg;
        drops_next   = drops_reg;
        k_next       = k_reg;
        k_first_next = k_first_reg;
        if (load)
        begin
            active_next  = 1'b1;
            flush_next   = job.flush;
            cur_sum_next = job.sum;
            drops_next   = job.drops;
            k_next       = '0;
            k_first_next = job.k_first;
        end
        else if (finishing)
        begin
            active_next = 1'b0;
        end
        else if (issue)
        begin
            k_next       = k_reg + 1'b1;
            cur_sum_next = cur_sum_reg
                         - cma_pkg::SUM_W'(drops_reg[k_reg[cma_pkg::DROP_IDX_W-1:0]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            mul_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        flush_reg    <= flush_next;
        cur_sum_reg  <= cur_sum_next;
        drops_reg    <= drops_next;
        k_reg        <= k_next;
        k_first_reg  <= k_first_next;
        prod_reg     <= cma_pkg::PROD_W'(cur_sum_reg) * cma_pkg::PROD_W'(RECIP_C);
        mul_last_reg <= flush_reg && last_k;
    end

    // The scaled product holds the quotient above the reciprocal's fraction bits.
    assign out_wr_item.average      = prod_reg[cma_pkg::RECIP_SHIFT +: cma_pkg::SAMPLE_W];
    assign out_wr_item.final_result = mul_last_reg;

    assign empty  = (out_count_reg == '0);
    assign result = outq_reg[out_rd_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        out_count_next = out_count_reg;
        if (mul_valid_reg && !do_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (do_pop && !mul_valid_reg)
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_valid_reg)
        begin
            outq_reg[out_wr_reg] <= out_wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (mul_valid_reg)
            begin
                out_wr_reg <= out_wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                out_rd_reg <= out_rd_reg + 1'b1;
            end
            out_count_reg <= out_count_next;
        end
    end

endmodule

// ===== rtl/core/cma_checker.sv =====
// Port-level checker of the centered moving average filter, bound to the top level.
module cma_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input cma_pkg::in_item_t  item,
    input logic               empty,
    input logic               pop,
    input cma_pkg::out_item_t result
);

    logic [cma_pkg::SEEN_W-1:0] in_block_reg, in_block_next;
    logic [6:0]                 owed_reg, owed_next;
    logic [3:0]                 finals_reg, finals_next;
    logic                       started_reg;
    logic                       acc, taken;

    assign acc   = push && !full;
    assign taken = pop && !empty;

    always_comb
    begin
        in_block_next = in_block_reg;
        owed_next     = owed_reg;
        finals_next   = finals_reg;
        if (acc)
        begin
            if (in_block_reg < cma_pkg::SEEN_W'(cma_pkg::HALF_SPAN + 1))
            begin
                in_block_next = in_block_reg + 1'b1;
            end
            if (item.block_end)
            begin
                owed_next     = owed_next + 7'(in_block_next);
                finals_next   = finals_next + 1'b1;
                in_block_next = '0;
            end
            else if (in_block_next == cma_pkg::SEEN_W'(cma_pkg::HALF_SPAN + 1))
            begin
                owed_next = owed_next + 1'b1;
            end
        end
        if (taken)
        begin
            owed_next = owed_next - 1'b1;
            if (result.final_result)
            begin
                finals_next = finals_next - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_block_reg <= '0;
            owed_reg     <= '0;
            finals_reg   <= '0;
            started_reg  <= 1'b0;
        end
        else
        begin
            in_block_reg <= in_block_next;
            owed_reg     <= owed_next;
            finals_reg   <= finals_next;
            started_reg  <= 1'b1;
        end
    end

    // A waiting result stays in place until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    // The first cycle after reset shows both queues idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (empty && !full))
        else $error("queues not idle after reset");

    // No result transaction happens unless a result is owed.
    assert property (@(posedge clk) disable iff (!rst_n)
        taken |-> (owed_reg != '0))
        else $error("result delivered that no sample caused");

    // A flagged result needs a block end that has not been answered yet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (taken && result.final_result) |-> (finals_reg != '0))
        else $error("final flag without an open block end");

    // With nothing owed, the result side shows empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (owed_reg == '0) |-> empty)
        else $error("result shown while nothing is owed");

endmodule

bind centered_moving_average_11 cma_checker u_cma_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ===== bench/centered_moving_average_11_check.sv =====
// Checker for the centered moving average filter: predicts every average and compares results.
module centered_moving_average_11_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  cma_pkg::in_item_t   item,
    input  logic                empty,
    input  logic                pop,
    input  cma_pkg::out_item_t  result,
    output int                  fail_count,
    output int                  pending,
    output int                  checked_count,
    output int                  final_count
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [cma_pkg::SAMPLE_W-1:0] window_hist [cma_pkg::WIN_LEN];
    logic [cma_pkg::SUM_W-1:0]    run_sum;
    logic [cma_pkg::SEEN_W-1:0]   fill_count;
    cma_pkg::out_item_t           expected_averages [$];

    task automatic clear_window();
        for (int i = 0; i < cma_pkg::WIN_LEN; i++)
        begin
            window_hist[i] = '0;
        end
        run_sum = '0;
        fill_count = '0;
    endtask

    task automatic queue_average(input logic [cma_pkg::SUM_W-1:0] total, input logic last);
        logic [cma_pkg::SUM_W-1:0] quotient;
        cma_pkg::out_item_t        avg;
        quotient = total / cma_pkg::SUM_W'(cma_pkg::WIN_LEN);
        avg.average = quotient[cma_pkg::SAMPLE_W-1:0];
        avg.final_result = last;
        expected_averages.push_back(avg);
    endtask

    task automatic track_sample(input cma_pkg::in_item_t it);
        logic [cma_pkg::SUM_W-1:0] partial;
        run_sum = run_sum - cma_pkg::SUM_W'(window_hist[cma_pkg::WIN_LEN-1]);
        for (int i = cma_pkg::WIN_LEN - 1; i > 0; i--)
        begin
            window_hist[i] = window_hist[i-1];
        end
        window_hist[0] = it.sample;
        run_sum = run_sum + cma_pkg::SUM_W'(it.sample);
        if (fill_count < cma_pkg::SEEN_W'(cma_pkg::WIN_LEN))
        begin
            fill_count = fill_count + 1'b1;
        end
        if (!it.block_end)
        begin
            if (fill_count >= cma_pkg::SEEN_W'(cma_pkg::HALF_SPAN + 1))
            begin
                queue_average(run_sum, 1'b0);
            end
        end
        else
        begin
            partial = run_sum;
            for (int k = 0; k <= cma_pkg::HALF_SPAN; k++)
            begin
                if (k > 0)
                begin
                    partial = partial - cma_pkg::SUM_W'(window_hist[cma_pkg::WIN_LEN-k]);
                end
                if (int'(fill_count) + k >= int'(cma_pkg::HALF_SPAN) + 1)
                begin
                    queue_average(partial, k == int'(cma_pkg::HALF_SPAN));
                end
            end
            clear_window();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            expected_averages.delete();
            fail_count <= 0;
            pending <= 0;
            checked_count <= 0;
            final_count <= 0;
        end
        else
        begin
            int mismatches;
            mismatches = 0;
            if (push && !full)
            begin
                track_sample(item);
            end
            if (pop && !empty)
            begin
                if (expected_averages.size() == 0)
                begin
                    $error("unexpected transaction: average %0d final_result %0b",
                           result.average, result.final_result);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    cma_pkg::out_item_t want;
                    want = expected_averages.pop_front();
                    checked_count <= checked_count + 1;
                    if (want.final_result)
                    begin
                        final_count <= final_count + 1;
                    end
                    if (result.average !== want.average)
                    begin
                        $error("average: expected %0d, actual %0d",
                               want.average, result.average);
                        mismatches = mismatches + 1;
                    end
                    if (result.final_result !== want.final_result)
                    begin
                        $error("final_result: expected %0b, actual %0b",
                               want.final_result, result.final_result);
                        mismatches = mismatches + 1;
                    end
                end
            end
            fail_count <= fail_count + mismatches;
            pending <= expected_averages.size();
        end
    end

endmodule

// ===== bench/centered_moving_average_11_test.sv =====
// Testbench top for the centered moving average filter: clock, reset, stimulus and verdict.
module centered_moving_average_11_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_SAMPLES = 220;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_TAIL = 20;
    localparam int CYCLE_LIMIT = 200000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    cma_pkg::in_item_t  item;
    logic               empty;
    logic               pop;
    cma_pkg::out_item_t result;

    int fail_count;
    int pending;
    int checked_count;
    int final_count;
    int samples_sent;
    int blocks_sent;
    int cycle_count;
    bit hold_off_request;

    centered_moving_average_11 u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    centered_moving_average_11_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .final_count   (final_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [cma_pkg::SAMPLE_W-1:0] pick_sample();
        logic [31:0] raw;
        int          roll;
        raw = $urandom();
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            return '0;
        end
        if (roll == 1)
        begin
            return '1;
        end
        if (roll == 2)
        begin
            return cma_pkg::SAMPLE_W'($urandom_range(0, 15));
        end
        return raw[cma_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic offer(input logic [cma_pkg::SAMPLE_W-1:0] value, input logic last);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{sample: value, block_end: last};
        do @(posedge clk); while (full);
        samples_sent++;
        if (last)
        begin
            blocks_sent++;
        end
    endtask

    task automatic send_block(input int len, input bit all_max);
        for (int i = 0; i < len; i++)
        begin
            offer(all_max ? '1 : pick_sample(), i == len - 1);
        end
    endtask

    initial
    begin
        int roll;
        int len;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        item = '0;
        hold_off_request = 1'b0;
        samples_sent = 0;
        blocks_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer('1, 1'b1);
        offer('0, 1'b1);
        offer('1, 1'b0);
        offer('0, 1'b0);
        offer('1, 1'b1);
        send_block(cma_pkg::HALF_SPAN + 1, 1'b0);
        send_block(cma_pkg::WIN_LEN + 1, 1'b1);

        hold_off_request = 1'b1;
        while (samples_sent < RANDOM_SAMPLES)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                len = $urandom_range(1, cma_pkg::HALF_SPAN);
            end
            else if (roll < 85)
            begin
                len = $urandom_range(cma_pkg::HALF_SPAN + 1, 24);
            end
            else
            begin
                len = $urandom_range(25, 60);
            end
            if (len > RANDOM_SAMPLES - samples_sent)
            begin
                len = RANDOM_SAMPLES - samples_sent;
            end
            send_block(len, 1'b0);
        end
        push <= 1'b0;
        @(posedge clk);

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Sent %0d samples in %0d blocks, including a long receiver hold-off.",
                 samples_sent, blocks_sent);
        $display("Checked %0d averages, %0d of them block-final.", checked_count, final_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("centered_moving_average_11_test passed");
        end
        else
        begin
            $display("centered_moving_average_11_test failed");
        end
        $finish;
    end

    initial
    begin
        int  on_len;
        int  off_len;
        bit  hold_off_done;
        hold_off_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_request && !hold_off_done)
            begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
            pop <= 1'b1;
            repeat (on_len) @(posedge clk);
            off_len = idle_gap();
            if (off_len > 0)
            begin
                pop <= 1'b0;
                repeat (off_len) @(posedge clk);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d averages outstanding.", pending);
        $display("centered_moving_average_11_test failed");
        $finish;
    end

endmodule
